/* src/ssd_pkg.sv */
// shared types, constants and segment tables for the seven-segment serial driver
// no dependencies
package ssd_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned CNT_W     = $clog2(WORD_BITS + 1);

  // reciprocal multipliers for 16-bit x: x/10 = (x*52429)>>19, x/100 = ((x>>2)*5243)>>17
  localparam logic [15:0] RECIP10   = 16'd52429;
  localparam logic [15:0] RECIP100  = 16'd5243;

  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [3:0]           digit_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // PCDE--------GFAB pattern used by the hundreds and ones positions
  function automatic logic [15:0] seg_pcde(input digit_t d);
    logic [15:0] p;
    case (d)
      4'd0:    p = 16'h7007;
      4'd1:    p = 16'h4001;
      4'd2:    p = 16'h300B;
      4'd3:    p = 16'h600B;
      4'd4:    p = 16'h400D;
      4'd5:    p = 16'h600E;
      4'd6:    p = 16'h700E;
      4'd7:    p = 16'h4003;
      4'd8:    p = 16'h700F;
      4'd9:    p = 16'h600F;
      default: p = 16'h0000;
    endcase
    return p;
  endfunction

  // ----PCDEGFAB---- pattern used by the tens position
  function automatic logic [15:0] seg_tens(input digit_t d);
    logic [15:0] p;
    case (d)
      4'd0:    p = 16'h0770;
      4'd1:    p = 16'h0410;
      4'd2:    p = 16'h03B0;
      4'd3:    p = 16'h06B0;
      4'd4:    p = 16'h04D0;
      4'd5:    p = 16'h06E0;
      4'd6:    p = 16'h07E0;
      4'd7:    p = 16'h0430;
      4'd8:    p = 16'h07F0;
      4'd9:    p = 16'h06F0;
      default: p = 16'h0000;
    endcase
    return p;
  endfunction

  // one-hot bar-graph segment, indices above eight light nothing
  function automatic word_t bar_pattern(input logic [3:0] idx);
    word_t p;
    case (idx)
      4'd1:    p = 32'h0100_0000;
      4'd2:    p = 32'h0200_0000;
      4'd3:    p = 32'h0400_0000;
      4'd4:    p = 32'h0800_0000;
      4'd5:    p = 32'h0080_0000;
      4'd6:    p = 32'h0040_0000;
      4'd7:    p = 32'h0020_0000;
      4'd8:    p = 32'h0010_0000;
      default: p = 32'h0000_0000;
    endcase
    return p;
  endfunction

endpackage

/* src/ssd_front.sv */
// front end: splits the value into decimal digits and assembles the display word
// depends on ssd_pkg
module ssd_front import ssd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [15:0] display_value,
  input  logic [3:0] bar_index,
  input  q_status_t  q_status,
  output logic       push,
  output word_t      push_word
);

  // stage 1: quotients by 10 and 100
  logic        s1_valid;
  logic [15:0] s1_value;
  logic [3:0]  s1_bar;
  logic [12:0] s1_q10;
  logic [9:0]  s1_q100;

  // stage 2: ones digit and second-level quotients
  logic        s2_valid;
  logic [3:0]  s2_bar;
  digit_t      s2_ones;
  logic [12:0] s2_q10;
  logic [9:0]  s2_q100;
  logic [9:0]  s2_q10q;
  logic [6:0]  s2_q100q;

  logic        s1_ready;
  logic        s2_ready;

  logic [31:0] prod10;
  logic [31:0] prod100;
  logic [28:0] prod_q10;
  logic [25:0] prod_q100;
  logic [15:0] ones_full;
  logic [12:0] tens_full;
  logic [9:0]  hund_full;
  digit_t      tens;
  digit_t      hund;

  assign s2_ready = !s2_valid || !q_status.full;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_stall = !s1_ready;
  assign push     = s2_valid && !q_status.full;

  assign prod10    = 32'(display_value) * 32'(RECIP10);
  assign prod100   = 32'(display_value[15:2]) * 32'(RECIP100);
  assign prod_q10  = 29'(s1_q10) * 29'(RECIP10);
  assign prod_q100 = 26'(s1_q100) * 26'(RECIP10);
  assign ones_full = s1_value - {s1_q10[12:0], 3'b000} - {2'b00, s1_q10, 1'b0};

  assign tens_full = s2_q10 - {s2_q10q, 3'b000} - {2'b00, s2_q10q, 1'b0};
  assign hund_full = s2_q100 - {s2_q100q, 3'b000} - {2'b00, s2_q100q, 1'b0};
  assign tens      = tens_full[3:0];
  assign hund      = hund_full[3:0];

  assign push_word = {seg_pcde(hund), 16'h0000} | {16'h0000, seg_tens(tens)}
                   | {16'h0000, seg_pcde(s2_ones)} | bar_pattern(s2_bar);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= in_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_value <= display_value;
      s1_bar   <= bar_index;
      s1_q10   <= prod10[31:19];
      s1_q100  <= prod100[26:17];
    end
    if (s2_ready && s1_valid) begin
      s2_bar   <= s1_bar;
      s2_ones  <= ones_full[3:0];
      s2_q10   <= s1_q10;
      s2_q100  <= s1_q100;
      s2_q10q  <= prod_q10[28:19];
      s2_q100q <= prod_q100[25:19];
    end
  end

endmodule

/* src/ssd_queue.sv */
// short word queue between the front end and the serializer
// depends on ssd_pkg
module ssd_queue import ssd_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  word_t     push_word,
  input  logic      pop,
  output word_t     pop_word,
  output q_status_t q_status
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  word_t            mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign q_status.full  = (count == CNT_W'(DEPTH));
  assign q_status.empty = (count == '0);
  assign pop_word       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

endmodule

/* src/ssd_back.sv */
// back end: shifts each queued word out lsb first and flags the last bit
// depends on ssd_pkg
module ssd_back import ssd_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  q_status_t q_status,
  input  word_t     pop_word,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output logic      serial_bit,
  output logic      last_bit
);

  word_t            out_word;
  logic [CNT_W-1:0] bits_left;
  logic             busy;
  logic             taken;
  logic             on_last;

  assign taken      = busy && !out_stall;
  assign on_last    = (bits_left == CNT_W'(1));
  assign pop        = !q_status.empty && (!busy || (taken && on_last));
  assign out_valid  = busy;
  assign serial_bit = out_word[0];
  assign last_bit   = on_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      bits_left <= '0;
    end else if (pop) begin
      busy      <= 1'b1;
      bits_left <= CNT_W'(WORD_BITS);
    end else if (taken) begin
      bits_left <= bits_left - 1'b1;
      if (on_last) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_word <= pop_word;
    end else if (taken) begin
      out_word <= {1'b0, out_word[WORD_BITS-1:1]};
    end
  end

endmodule

/* src/seven_segment_serial_display_driver_top.sv */
// top level of the three-digit seven-segment serial display driver
// depends on ssd_pkg, ssd_front, ssd_queue, ssd_back
//
// usage:
//   input channel: in_valid / in_stall with display_value (16 bits) and
//   bar_index (4 bits). an item is taken at a clock edge with in_valid high
//   and in_stall low. the value is shown modulo 1000 on three digits, and
//   bar_index 1 to 8 lights one bar segment (0 and 9 to 15 light none).
//   output channel: out_valid / out_stall with serial_bit and last_bit. each
//   input item yields 32 output items, bit 0 of the display word first;
//   last_bit is high on the 32nd so the latch pulse can follow it.
//   an item taken into the first front stage reaches the outputs through
//   the second front stage, the queue write and the serializer load.
//   the serializer sends one bit per cycle while out_stall is low; a queued
//   word loads as the last bit goes and is on the outputs in the cycle after.
//   the front end keeps taking items until the queue of QUEUE_DEPTH words
//   and both front stages are full.
//   reset clears the pipeline valids, the queue and the serializer; nothing
//   is sent afterward until an item arrives.
//   while out_stall is high the current bit and last_bit hold; the front
//   end backs up and raises in_stall only once all its storage is full.
module seven_segment_serial_display_driver_top import ssd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] display_value,
  input  logic [3:0]  bar_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        serial_bit,
  output logic        last_bit
);

  // queue handshake between the front and back ends
  q_status_t q_status;
  logic      push;
  word_t     push_word;
  logic      pop;
  word_t     pop_word;

  // digit split and word assembly
  ssd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .display_value (display_value),
    .bar_index     (bar_index),
    .q_status      (q_status),
    .push          (push),
    .push_word     (push_word)
  );

  // decouples word assembly from the bit-serial output
  ssd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .pop_word  (pop_word),
    .q_status  (q_status)
  );

  // one bit per accepted output item, lsb first
  ssd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_status   (q_status),
    .pop_word   (pop_word),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .serial_bit (serial_bit),
    .last_bit   (last_bit)
  );

endmodule
